// ===== rtl/i2cmbe_pkg.sv =====
// Shared types and constants for the I2C master byte engine.
// No dependencies; imported by the top level and the phase step logic.

package i2cmbe_pkg;

	localparam int BYTE_BITS = 8;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;

	// Command codes carried in the kind field.
	localparam logic [2:0] KIND_NONE     = 3'd0;
	localparam logic [2:0] KIND_START    = 3'd1;
	localparam logic [2:0] KIND_STOP     = 3'd2;
	localparam logic [2:0] KIND_WRITE    = 3'd3;
	localparam logic [2:0] KIND_READ     = 3'd4;
	localparam logic [2:0] KIND_WAIT_ACK = 3'd5;
	localparam logic [2:0] KIND_ACK      = 3'd6;
	localparam logic [2:0] KIND_NACK     = 3'd7;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ACK_WAIT_LIMIT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_PHASE = 1'd1;

	// Sequencer state codes.
	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_START    = 4'd1;
	localparam logic [3:0] ST_STOP     = 4'd2;
	localparam logic [3:0] ST_WRITE    = 4'd3;
	localparam logic [3:0] ST_RDPRE    = 4'd4;
	localparam logic [3:0] ST_READ     = 4'd5;
	localparam logic [3:0] ST_RDPOST   = 4'd6;
	localparam logic [3:0] ST_WSET     = 4'd7;
	localparam logic [3:0] ST_WPOLL    = 4'd8;
	localparam logic [3:0] ST_WDONE    = 4'd9;
	localparam logic [3:0] ST_AUTOSTOP = 4'd10;
	localparam logic [3:0] ST_ACK      = 4'd11;
	localparam logic [3:0] ST_NACK     = 4'd12;

	localparam logic [15:0] ACK_WAIT_LIMIT_RST  = 16'd65500;
	localparam logic [9:0]  TICKS_PER_PHASE_RST = 10'd8;

	// Complete architectural state of the sequencer.
	typedef struct packed {
		logic [3:0]  cmd;
		logic [1:0]  phase;
		logic [9:0]  tick;
		logic [3:0]  bits;
		logic [7:0]  shift;
		logic [15:0] wait_cnt;
		logic        scl;
		logic        sda;
		logic        oe;
		logic [7:0]  last_read;
		logic        ok;
		logic        timeout;
	} state_t;

endpackage

// ===== rtl/i2cmbe_step.sv =====
// Next-state logic of the I2C master byte engine for one tick.
// Depends on i2cmbe_pkg for the state record and the state and command codes.

module i2cmbe_step (
	input  i2cmbe_pkg::state_t cur,
	input  logic [2:0]         kind,
	input  logic [7:0]         write_byte,
	input  logic               sda_level,
	input  logic [15:0]        ack_wait_limit,
	input  logic [9:0]         ticks_per_phase,
	output i2cmbe_pkg::state_t nxt,
	output logic               done
);
	import i2cmbe_pkg::*;

	// Line and shift register updates made on entry to a phase.
	function automatic state_t enter_phase(state_t s, logic sda);
		state_t r;
		r = s;
		unique case (s.cmd) inside
			ST_START: begin
				if (s.phase == 2'd0) begin r.oe = 1'b1; r.sda = 1'b1; end
				else if (s.phase == 2'd1) r.scl = 1'b1;
				else if (s.phase == 2'd2) r.sda = 1'b0;
				else r.scl = 1'b0;
			end
			ST_STOP, ST_AUTOSTOP: begin
				if (s.phase == 2'd0) begin r.oe = 1'b1; r.scl = 1'b0; end
				else if (s.phase == 2'd1) r.sda = 1'b0;
				else if (s.phase == 2'd2) r.scl = 1'b1;
				else r.sda = 1'b1;
			end
			ST_ACK: begin
				if (s.phase == 2'd0) begin r.oe = 1'b1; r.sda = 1'b0; end
				else if (s.phase == 2'd1) r.scl = 1'b1;
				else if (s.phase == 2'd2) r.scl = 1'b0;
				else r.sda = 1'b1;
			end
			ST_NACK: begin
				if (s.phase == 2'd0) begin r.oe = 1'b1; r.sda = 1'b1; end
				else if (s.phase == 2'd1) r.scl = 1'b1;
				else r.scl = 1'b0;
			end
			ST_WRITE: begin
				if (s.phase == 2'd0) begin r.oe = 1'b1; r.scl = 1'b0; end
				else if (s.phase == 2'd1) r.sda = s.shift[7];
				else if (s.phase == 2'd3) r.scl = 1'b1;
			end
			ST_RDPRE: begin
				r.oe = 1'b0; r.sda = 1'b0; r.scl = 1'b0;
			end
			ST_READ: begin
				if (s.phase == 2'd0) begin
					r.shift = {s.shift[6:0], 1'b0};
					r.scl = 1'b1;
				end else if (s.phase == 2'd1) begin
					r.shift = {s.shift[7:1], sda};
				end else if (s.phase == 2'd3) begin
					r.scl = 1'b0;
				end
			end
			ST_RDPOST: begin
				r.scl = 1'b0; r.oe = 1'b1;
			end
			ST_WSET: begin
				if (s.phase == 2'd0) begin r.oe = 1'b1; r.scl = 1'b0; end
				else if (s.phase == 2'd1) r.sda = 1'b1;
				else begin r.oe = 1'b0; r.sda = 1'b0; r.scl = 1'b1; end
			end
			ST_WDONE: r.oe = 1'b1;
			default: ;
		endcase
		return r;
	endfunction

	function automatic state_t go(state_t s, logic [3:0] st, logic [1:0] p, logic sda);
		s.cmd = st;
		s.phase = p;
		return enter_phase(s, sda);
	endfunction

	logic [9:0] tpp_eff;
	logic [9:0] tick_inc;
	logic [3:0] bits_inc;
	logic [1:0] phase_inc;
	logic       finish;

	assign tpp_eff   = (ticks_per_phase == 10'd0) ? 10'd1 : ticks_per_phase;
	assign tick_inc  = cur.tick + 10'd1;
	assign bits_inc  = cur.bits + 4'd1;
	assign phase_inc = cur.phase + 2'd1;

	always_comb begin
		nxt = cur;
		finish = 1'b0;
		if (cur.cmd == ST_IDLE) begin
			nxt.tick = '0;
			nxt.bits = '0;
			unique case (kind)
				KIND_START: nxt = go(nxt, ST_START, 2'd0, sda_level);
				KIND_STOP:  nxt = go(nxt, ST_STOP, 2'd0, sda_level);
				KIND_WRITE: begin
					nxt.shift = write_byte;
					nxt = go(nxt, ST_WRITE, 2'd0, sda_level);
				end
				KIND_READ: begin
					nxt.shift = '0;
					nxt = go(nxt, ST_RDPRE, 2'd0, sda_level);
				end
				KIND_WAIT_ACK: begin
					nxt.wait_cnt = (ack_wait_limit == 16'd0) ? 16'd1 : ack_wait_limit;
					nxt = go(nxt, ST_WSET, 2'd0, sda_level);
				end
				KIND_ACK:  nxt = go(nxt, ST_ACK, 2'd0, sda_level);
				KIND_NACK: nxt = go(nxt, ST_NACK, 2'd0, sda_level);
				default: ;
			endcase
		end else begin
			nxt.tick = tick_inc;
			if (tick_inc >= tpp_eff) begin
				nxt.tick = '0;
				unique case (cur.cmd) inside
					ST_WRITE: begin
						if (cur.phase != 2'd3) begin
							nxt = go(nxt, ST_WRITE, phase_inc, sda_level);
						end else begin
							nxt.shift = {cur.shift[6:0], 1'b0};
							nxt.bits = bits_inc;
							if (bits_inc >= 4'(BYTE_BITS)) finish = 1'b1;
							else nxt = go(nxt, ST_WRITE, 2'd0, sda_level);
						end
					end
					ST_RDPRE: begin
						nxt.bits = '0;
						nxt = go(nxt, ST_READ, 2'd0, sda_level);
					end
					ST_READ: begin
						if (cur.phase != 2'd3) begin
							nxt = go(nxt, ST_READ, phase_inc, sda_level);
						end else begin
							nxt.bits = bits_inc;
							if (bits_inc >= 4'(BYTE_BITS))
								nxt = go(nxt, ST_RDPOST, 2'd0, sda_level);
							else
								nxt = go(nxt, ST_READ, 2'd0, sda_level);
						end
					end
					ST_RDPOST: begin
						nxt.last_read = cur.shift;
						finish = 1'b1;
					end
					ST_WSET: begin
						if (cur.phase < 2'd2) nxt = go(nxt, ST_WSET, phase_inc, sda_level);
						else nxt = go(nxt, ST_WPOLL, 2'd0, sda_level);
					end
					ST_WPOLL: begin
						if (!sda_level) begin
							nxt = go(nxt, ST_WDONE, 2'd0, sda_level);
						end else if (cur.wait_cnt <= 16'd1) begin
							nxt.wait_cnt = '0;
							nxt = go(nxt, ST_AUTOSTOP, 2'd0, sda_level);
						end else begin
							nxt.wait_cnt = cur.wait_cnt - 16'd1;
						end
					end
					ST_WDONE: begin
						nxt.scl = 1'b0;
						nxt.ok = 1'b1;
						nxt.timeout = 1'b0;
						finish = 1'b1;
					end
					ST_AUTOSTOP: begin
						if (cur.phase != 2'd3) begin
							nxt = go(nxt, ST_AUTOSTOP, phase_inc, sda_level);
						end else begin
							nxt.ok = 1'b0;
							nxt.timeout = 1'b1;
							finish = 1'b1;
						end
					end
					ST_NACK: begin
						if (cur.phase < 2'd2) nxt = go(nxt, ST_NACK, phase_inc, sda_level);
						else finish = 1'b1;
					end
					ST_START, ST_STOP, ST_ACK: begin
						if (cur.phase != 2'd3) nxt = go(nxt, cur.cmd, phase_inc, sda_level);
						else finish = 1'b1;
					end
					default: finish = 1'b1;
				endcase
				if (finish) begin
					nxt.cmd = ST_IDLE;
					nxt.phase = 2'd0;
				end
			end
		end
	end

	assign done = finish;

endmodule

// ===== rtl/i2c_master_byte_engine.sv =====
// Top level of the I2C master byte engine: handshakes, configuration and state registers.
// Depends on i2cmbe_pkg and i2cmbe_step.
//
// Usage: every transaction on the input channel is one tick of the bus sequencer. It carries
// a command kind, the byte for a write command and the sampled SDA level. A command is taken
// only while the engine is idle; ticks that arrive while busy just advance the current phase.
// Each input transaction produces exactly one output transaction with the bus line levels,
// the busy flag, a one-tick done pulse, the last read byte and the acknowledge outcome.
// Configuration writes (index 0 ack_wait_limit, index 1 ticks_per_phase) use their own
// valid/ready channel, are always ready, and are expected only while the engine is idle.
// Between input acceptance and the presented result lie one input register stage and one
// result register, with the next-state logic in between.
// Throughput is one transaction per cycle while the receiver does not stall; the sequencer
// state register feeds back directly, so back-to-back ticks never wait on each other.
// When the receiver stalls, the result register holds its transaction, the input stage fills
// and then in_ready drops; nothing is lost or repeated.
// Reset puts the sequencer in idle with SCL high, SDA driven high, read byte and
// acknowledge flags cleared, and the configuration registers at their default values.

module i2c_master_byte_engine (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [i2cmbe_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [i2cmbe_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [2:0]                            kind,
	input  logic [7:0]                            write_byte,
	input  logic                                  sda_level,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  scl_level,
	output logic                                  sda_drive,
	output logic                                  sda_output_enable,
	output logic                                  busy_res,
	output logic                                  done_res,
	output logic [7:0]                            read_byte,
	output logic                                  ack_ok,
	output logic                                  ack_timeout
);
	import i2cmbe_pkg::*;

	// Configuration registers.
	logic [15:0] ack_wait_limit_q;
	logic [9:0]  ticks_per_phase_q;

	// Input stage.
	logic        valid_s1;
	logic [2:0]  kind_s1;
	logic [7:0]  write_byte_s1;
	logic        sda_level_s1;

	// Sequencer state.
	state_t      state_q;
	state_t      state_nxt;
	logic        done_nxt;

	// Result stage.
	logic        valid_s2;
	logic        scl_s2;
	logic        sda_s2;
	logic        oe_s2;
	logic        busy_s2;
	logic        done_s2;
	logic [7:0]  read_byte_s2;
	logic        ok_s2;
	logic        timeout_s2;

	logic        out_free;
	logic        advance;
	logic        in_fire;

	// The result register is free when empty or being drained this cycle.
	assign out_free  = !valid_s2 || out_ready;
	assign advance   = valid_s1 && out_free;
	assign in_ready  = !valid_s1 || out_free;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_wait_limit_q  <= ACK_WAIT_LIMIT_RST;
			ticks_per_phase_q <= TICKS_PER_PHASE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ACK_WAIT_LIMIT:  ack_wait_limit_q  <= cfg_data[15:0];
				REG_TICKS_PER_PHASE: ticks_per_phase_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_s1       <= kind;
			write_byte_s1 <= write_byte;
			sda_level_s1  <= sda_level;
		end
	end

	i2cmbe_step u_step (
		.cur             (state_q),
		.kind            (kind_s1),
		.write_byte      (write_byte_s1),
		.sda_level       (sda_level_s1),
		.ack_wait_limit  (ack_wait_limit_q),
		.ticks_per_phase (ticks_per_phase_q),
		.nxt             (state_nxt),
		.done            (done_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.cmd       <= ST_IDLE;
			state_q.phase     <= '0;
			state_q.tick      <= '0;
			state_q.bits      <= '0;
			state_q.shift     <= '0;
			state_q.wait_cnt  <= '0;
			state_q.scl       <= 1'b1;
			state_q.sda       <= 1'b1;
			state_q.oe        <= 1'b1;
			state_q.last_read <= '0;
			state_q.ok        <= 1'b0;
			state_q.timeout   <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			scl_s2       <= state_nxt.scl;
			sda_s2       <= state_nxt.sda;
			oe_s2        <= state_nxt.oe;
			busy_s2      <= (state_nxt.cmd != ST_IDLE);
			done_s2      <= done_nxt;
			read_byte_s2 <= state_nxt.last_read;
			ok_s2        <= state_nxt.ok;
			timeout_s2   <= state_nxt.timeout;
		end
	end

	assign out_valid         = valid_s2;
	assign scl_level         = scl_s2;
	assign sda_drive         = sda_s2;
	assign sda_output_enable = oe_s2;
	assign busy_res          = busy_s2;
	assign done_res          = done_s2;
	assign read_byte         = read_byte_s2;
	assign ack_ok            = ok_s2;
	assign ack_timeout       = timeout_s2;

endmodule

// ===== rtl/i2cmbe_checker.sv =====
// Port-level checker for the I2C master byte engine, with its bind to the top level.
// Depends only on the ports of i2c_master_byte_engine.

module i2cmbe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       sda_drive,
	input logic       sda_output_enable,
	input logic       busy_res,
	input logic       done_res,
	input logic [7:0] read_byte,
	input logic       ack_ok,
	input logic       ack_timeout
);

	// A finished command always leaves the engine idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done reported while still busy");

	// An acknowledge wait ends either acknowledged or timed out, never both.
	a_ack_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(ack_ok && ack_timeout))
		else $error("ack_ok and ack_timeout both set");

	// A released SDA line is never paired with a high drive level.
	a_release_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sda_output_enable |-> !sda_drive)
		else $error("SDA released with drive level high");

	// A stalled result transaction stays valid and holds its read byte and done flag.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_byte) && $stable(done_res))
		else $error("stalled result changed");

endmodule

bind i2c_master_byte_engine i2cmbe_checker u_i2cmbe_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (out_valid),
	.out_ready         (out_ready),
	.sda_drive         (sda_drive),
	.sda_output_enable (sda_output_enable),
	.busy_res          (busy_res),
	.done_res          (done_res),
	.read_byte         (read_byte),
	.ack_ok            (ack_ok),
	.ack_timeout       (ack_timeout)
);

// ===== dv/i2c_master_byte_engine_tb.sv =====
// Self-checking testbench for the I2C master byte engine: directed and random bus ticks
// are checked against a tick-accurate bus sequencer model. Depends on i2cmbe_pkg and the RTL.

module i2c_master_byte_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import i2cmbe_pkg::*;

	// The watchdog fires after this many cycles in which no transaction is accepted
	// on any channel.
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_REPORTS = 10;
	localparam int RANDOM_PHASES = 8;
	localparam int TICKS_PER_RANDOM_PHASE = 20;

	// One input transaction: a sequencer tick with its command and sampled SDA level.
	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] wbyte;
		logic       sda;
	} bus_tick_t;

	// One output transaction: the line levels and status after the tick.
	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       oe;
		logic       busy;
		logic       done;
		logic [7:0] rbyte;
		logic       ok;
		logic       tmo;
	} bus_levels_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [2:0] kind = KIND_NONE;
	logic [7:0] write_byte = 8'h00;
	logic       sda_level = 1'b0;

	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       scl_level;
	logic       sda_drive;
	logic       sda_output_enable;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_byte;
	logic       ack_ok;
	logic       ack_timeout;

	// Stimulus and scoreboard bookkeeping.
	bus_tick_t   pending_ticks[$];
	bus_levels_t expected_bus_q[$];
	int          ticks_queued = 0;
	int          ticks_sent = 0;
	int          ticks_taken = 0;
	int          mismatches = 0;
	int          quiet_cycles = 0;

	// Knobs that the stimulus sequence turns between phases.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int sda_high_pct = 50;

	// Model copy of the configuration registers.
	logic [15:0] mdl_limit = ACK_WAIT_LIMIT_RST;
	logic [9:0]  mdl_tpp = TICKS_PER_PHASE_RST;

	// Model copy of the sequencer state, at its reset values.
	logic [3:0]  mdl_cmd = ST_IDLE;
	logic [1:0]  mdl_phase = 2'd0;
	logic [9:0]  mdl_tick = 10'd0;
	logic [3:0]  mdl_bits = 4'd0;
	logic [7:0]  mdl_shift = 8'h00;
	logic [15:0] mdl_wait = 16'd0;
	logic        mdl_scl = 1'b1;
	logic        mdl_sda = 1'b1;
	logic        mdl_oe = 1'b1;
	logic [7:0]  mdl_last_read = 8'h00;
	logic        mdl_ok = 1'b0;
	logic        mdl_tmo = 1'b0;

	i2c_master_byte_engine DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.kind              (kind),
		.write_byte        (write_byte),
		.sda_level         (sda_level),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.scl_level         (scl_level),
		.sda_drive         (sda_drive),
		.sda_output_enable (sda_output_enable),
		.busy_res          (busy_res),
		.done_res          (done_res),
		.read_byte         (read_byte),
		.ack_ok            (ack_ok),
		.ack_timeout       (ack_timeout)
	);

	// 12 ns clock period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Applies the line changes that happen on entry into a bus phase. The read state also
	// shifts and samples here, so the sampled SDA level is passed in.
	function automatic void enter_phase(input logic sda);
		case (mdl_cmd)
			ST_START: begin
				case (mdl_phase)
					2'd0: begin
						mdl_oe = 1'b1;
						mdl_sda = 1'b1;
					end
					2'd1: mdl_scl = 1'b1;
					2'd2: mdl_sda = 1'b0;
					default: mdl_scl = 1'b0;
				endcase
			end
			ST_STOP, ST_AUTOSTOP: begin
				case (mdl_phase)
					2'd0: begin
						mdl_oe = 1'b1;
						mdl_scl = 1'b0;
					end
					2'd1: mdl_sda = 1'b0;
					2'd2: mdl_scl = 1'b1;
					default: mdl_sda = 1'b1;
				endcase
			end
			ST_ACK: begin
				case (mdl_phase)
					2'd0: begin
						mdl_oe = 1'b1;
						mdl_sda = 1'b0;
					end
					2'd1: mdl_scl = 1'b1;
					2'd2: mdl_scl = 1'b0;
					default: mdl_sda = 1'b1;
				endcase
			end
			ST_NACK: begin
				case (mdl_phase)
					2'd0: begin
						mdl_oe = 1'b1;
						mdl_sda = 1'b1;
					end
					2'd1: mdl_scl = 1'b1;
					default: mdl_scl = 1'b0;
				endcase
			end
			ST_WRITE: begin
				case (mdl_phase)
					2'd0: begin
						mdl_oe = 1'b1;
						mdl_scl = 1'b0;
					end
					2'd1: mdl_sda = mdl_shift[7];
					2'd3: mdl_scl = 1'b1;
					default: ;
				endcase
			end
			ST_RDPRE: begin
				mdl_oe = 1'b0;
				mdl_sda = 1'b0;
				mdl_scl = 1'b0;
			end
			ST_READ: begin
				case (mdl_phase)
					2'd0: begin
						mdl_shift = mdl_shift << 1;
						mdl_scl = 1'b1;
					end
					2'd1: mdl_shift[0] = sda;
					2'd3: mdl_scl = 1'b0;
					default: ;
				endcase
			end
			ST_RDPOST: begin
				mdl_scl = 1'b0;
				mdl_oe = 1'b1;
			end
			ST_WSET: begin
				case (mdl_phase)
					2'd0: begin
						mdl_oe = 1'b1;
						mdl_scl = 1'b0;
					end
					2'd1: mdl_sda = 1'b1;
					default: begin
						mdl_oe = 1'b0;
						mdl_sda = 1'b0;
						mdl_scl = 1'b1;
					end
				endcase
			end
			ST_WDONE: mdl_oe = 1'b1;
			default: ;
		endcase
	endfunction

	function automatic void enter_state(input logic [3:0] st, input logic [1:0] ph,
			input logic sda);
		mdl_cmd = st;
		mdl_phase = ph;
		enter_phase(sda);
	endfunction

	// Advances the sequencer model by one tick and returns the levels the block should show.
	task automatic advance_bus_model(input bus_tick_t t, output bus_levels_t res);
		logic [9:0] tpp;
		logic       finished;
		tpp = (mdl_tpp == 10'd0) ? 10'd1 : mdl_tpp;
		finished = 1'b0;
		if (mdl_cmd == ST_IDLE) begin
			// A new command is only taken here; the counters start over for it.
			mdl_tick = 10'd0;
			mdl_bits = 4'd0;
			case (t.kind)
				KIND_START: enter_state(ST_START, 2'd0, t.sda);
				KIND_STOP: enter_state(ST_STOP, 2'd0, t.sda);
				KIND_WRITE: begin
					mdl_shift = t.wbyte;
					enter_state(ST_WRITE, 2'd0, t.sda);
				end
				KIND_READ: begin
					mdl_shift = 8'h00;
					enter_state(ST_RDPRE, 2'd0, t.sda);
				end
				KIND_WAIT_ACK: begin
					// The wait budget is reloaded for every wait; a zero limit counts as one.
					mdl_wait = (mdl_limit == 16'd0) ? 16'd1 : mdl_limit;
					enter_state(ST_WSET, 2'd0, t.sda);
				end
				KIND_ACK: enter_state(ST_ACK, 2'd0, t.sda);
				KIND_NACK: enter_state(ST_NACK, 2'd0, t.sda);
				default: ;
			endcase
		end else begin
			mdl_tick = mdl_tick + 10'd1;
			if (mdl_tick >= tpp) begin
				mdl_tick = 10'd0;
				case (mdl_cmd)
					ST_WRITE: begin
						if (mdl_phase < 2'd3) begin
							enter_state(ST_WRITE, mdl_phase + 2'd1, t.sda);
						end else begin
							mdl_shift = mdl_shift << 1;
							mdl_bits = mdl_bits + 4'd1;
							if (mdl_bits >= BYTE_BITS) finished = 1'b1;
							else enter_state(ST_WRITE, 2'd0, t.sda);
						end
					end
					ST_RDPRE: begin
						mdl_bits = 4'd0;
						enter_state(ST_READ, 2'd0, t.sda);
					end
					ST_READ: begin
						if (mdl_phase < 2'd3) begin
							enter_state(ST_READ, mdl_phase + 2'd1, t.sda);
						end else begin
							mdl_bits = mdl_bits + 4'd1;
							if (mdl_bits >= BYTE_BITS) enter_state(ST_RDPOST, 2'd0, t.sda);
							else enter_state(ST_READ, 2'd0, t.sda);
						end
					end
					ST_RDPOST: begin
						mdl_last_read = mdl_shift;
						finished = 1'b1;
					end
					ST_WSET: begin
						if (mdl_phase < 2'd2) enter_state(ST_WSET, mdl_phase + 2'd1, t.sda);
						else enter_state(ST_WPOLL, 2'd0, t.sda);
					end
					ST_WPOLL: begin
						// One SDA sample per phase: low is the acknowledge, high uses budget.
						if (!t.sda) begin
							enter_state(ST_WDONE, 2'd0, t.sda);
						end else if (mdl_wait <= 16'd1) begin
							mdl_wait = 16'd0;
							enter_state(ST_AUTOSTOP, 2'd0, t.sda);
						end else begin
							mdl_wait = mdl_wait - 16'd1;
						end
					end
					ST_WDONE: begin
						mdl_scl = 1'b0;
						mdl_ok = 1'b1;
						mdl_tmo = 1'b0;
						finished = 1'b1;
					end
					ST_AUTOSTOP: begin
						if (mdl_phase < 2'd3) begin
							enter_state(ST_AUTOSTOP, mdl_phase + 2'd1, t.sda);
						end else begin
							mdl_ok = 1'b0;
							mdl_tmo = 1'b1;
							finished = 1'b1;
						end
					end
					ST_NACK: begin
						if (mdl_phase < 2'd2) enter_state(ST_NACK, mdl_phase + 2'd1, t.sda);
						else finished = 1'b1;
					end
					ST_START, ST_STOP, ST_ACK: begin
						if (mdl_phase < 2'd3) enter_state(mdl_cmd, mdl_phase + 2'd1, t.sda);
						else finished = 1'b1;
					end
					default: finished = 1'b1;
				endcase
				if (finished) begin
					mdl_cmd = ST_IDLE;
					mdl_phase = 2'd0;
				end
			end
		end
		res = '{scl: mdl_scl, sda: mdl_sda, oe: mdl_oe, busy: (mdl_cmd != ST_IDLE),
			done: finished, rbyte: mdl_last_read, ok: mdl_ok, tmo: mdl_tmo};
	endtask

	// Input driver. Everything changes at the falling edge, clear of the rising
	// sampling edge. A new tick is offered only once every tick sent so far was accepted,
	// so valid and the payload hold steady while the block is not ready.
	always @(negedge clk) begin : tick_driver
		bus_tick_t nxt;
		if (!in_valid || ticks_taken == ticks_sent) begin
			if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = pending_ticks.pop_front();
				ticks_sent++;
				in_valid <= 1'b1;
				kind <= nxt.kind;
				write_byte <= nxt.wbyte;
				sda_level <= nxt.sda;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Monitor. At each rising edge it notes accepted input transactions and feeds them to
	// the model, applies accepted configuration writes, checks every accepted output
	// transaction against the oldest prediction, and keeps the watchdog.
	always @(posedge clk) begin : bus_monitor
		bus_levels_t want;
		bus_levels_t got;
		logic        moved;
		if (arst_n) begin
			moved = 1'b0;
			if (cfg_valid && cfg_ready) begin
				moved = 1'b1;
				case (cfg_index)
					REG_ACK_WAIT_LIMIT: mdl_limit = cfg_data;
					REG_TICKS_PER_PHASE: mdl_tpp = cfg_data[9:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				moved = 1'b1;
				advance_bus_model('{kind: kind, wbyte: write_byte, sda: sda_level}, want);
				expected_bus_q.push_back(want);
				ticks_taken++;
			end
			if (out_valid && out_ready) begin
				moved = 1'b1;
				got = '{scl: scl_level, sda: sda_drive, oe: sda_output_enable, busy: busy_res,
					done: done_res, rbyte: read_byte, ok: ack_ok, tmo: ack_timeout};
				if (expected_bus_q.size() == 0) begin
					if (mismatches < MAX_REPORTS)
						$display("%0t: output transaction with no prediction waiting", $realtime);
					mismatches++;
				end else begin
					want = expected_bus_q.pop_front();
					if (got !== want) begin
						if (mismatches < MAX_REPORTS) begin
							$display("%0t: mismatch expected scl=%b sda=%b oe=%b busy=%b done=%b",
								$realtime, want.scl, want.sda, want.oe, want.busy, want.done);
							$display("    rd=%h ok=%b tmo=%b | got scl=%b sda=%b oe=%b busy=%b",
								want.rbyte, want.ok, want.tmo, got.scl, got.sda, got.oe, got.busy);
							$display("    done=%b rd=%h ok=%b tmo=%b",
								got.done, got.rbyte, got.ok, got.tmo);
						end
						mismatches++;
					end
				end
			end
			if (moved) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("%0t: watchdog expired with no transaction accepted", $realtime);
					$display("RESULT: ERROR");
					$finish;
				end
			end
		end
	end

	function automatic logic pick_sda();
		return ($urandom_range(99) < sda_high_pct);
	endfunction

	task automatic push_tick(input logic [2:0] k, input logic [7:0] b, input logic s);
		pending_ticks.push_back('{kind: k, wbyte: b, sda: s});
		ticks_queued++;
	endtask

	// Waits until every queued tick was accepted and every prediction was matched.
	task automatic wait_drained();
		while (ticks_taken != ticks_queued || expected_bus_q.size() != 0) @(posedge clk);
	endtask

	// Feeds empty ticks until the model says the current command is over, so the block
	// ends up idle with nothing outstanding.
	task automatic settle();
		int batch;
		wait_drained();
		while (mdl_cmd != ST_IDLE) begin
			batch = (mdl_tpp < 10'd8) ? 8 : int'(mdl_tpp);
			repeat (batch) push_tick(KIND_NONE, 8'($urandom_range(255)), pick_sda());
			wait_drained();
		end
	endtask

	task automatic run_cmd(input logic [2:0] k, input logic [7:0] b, input int high_pct);
		sda_high_pct = high_pct;
		push_tick(k, b, pick_sda());
		settle();
	endtask

	// Configuration write; only called while the engine is idle and fully drained.
	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		logic [15:0] limit_word;
		logic [15:0] tpp_word;
		int          r;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part with the reset configuration. An empty tick while idle does nothing.
		run_cmd(KIND_NONE, 8'h00, 0);
		run_cmd(KIND_START, 8'h00, 50);
		// SDA held low: the slave acknowledges on the first poll.
		run_cmd(KIND_WAIT_ACK, 8'h00, 0);

		// Single-tick phases keep the remaining directed commands short.
		set_reg(REG_TICKS_PER_PHASE, 16'd1);
		run_cmd(KIND_WRITE, 8'hFF, 50);
		run_cmd(KIND_WRITE, 8'hA5, 50);
		// Reads of all ones and all zeros.
		run_cmd(KIND_READ, 8'h00, 100);
		run_cmd(KIND_READ, 8'h00, 0);
		run_cmd(KIND_ACK, 8'h00, 50);
		run_cmd(KIND_NACK, 8'h00, 50);
		run_cmd(KIND_STOP, 8'h00, 50);
		// A command offered while busy must be ignored.
		sda_high_pct = 50;
		push_tick(KIND_START, 8'h00, 1'b1);
		push_tick(KIND_WRITE, 8'h3C, 1'b0);
		settle();

		// Shortest wait budget: SDA stuck high runs into a timeout and an automatic stop.
		set_reg(REG_ACK_WAIT_LIMIT, 16'd1);
		run_cmd(KIND_WAIT_ACK, 8'h00, 100);
		run_cmd(KIND_WAIT_ACK, 8'h00, 0);
		// Zero in either register behaves as one.
		set_reg(REG_ACK_WAIT_LIMIT, 16'd0);
		set_reg(REG_TICKS_PER_PHASE, 16'd0);
		run_cmd(KIND_WAIT_ACK, 8'h00, 100);
		run_cmd(KIND_READ, 8'h00, 50);
		// Largest wait budget, and a phase length word whose upper bits are all set.
		set_reg(REG_ACK_WAIT_LIMIT, 16'hFFFF);
		set_reg(REG_TICKS_PER_PHASE, 16'hFC01);
		run_cmd(KIND_WAIT_ACK, 8'h00, 0);

		// Random part. Each phase gets its own register settings, idling pattern and SDA
		// bias. Any kind may come on any tick: while busy it only advances the phase.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			r = $urandom_range(9);
			if (r < 6) limit_word = 16'($urandom_range(0, 4));
			else if (r < 9) limit_word = 16'($urandom_range(5, 40));
			else limit_word = 16'hFFFF;
			// The upper bits of the data word are not part of the phase length.
			tpp_word[15:10] = 6'($urandom_range(63));
			tpp_word[9:0] = ($urandom_range(3) == 0) ? 10'($urandom_range(4, 6))
				: 10'($urandom_range(0, 3));
			set_reg(REG_ACK_WAIT_LIMIT, limit_word);
			set_reg(REG_TICKS_PER_PHASE, tpp_word);
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 62;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 62;
				end
				default: begin
					send_idle_pct = 14;
					recv_stall_pct = 14;
				end
			endcase
			case (ph % 3)
				0: sda_high_pct = 50;
				1: sda_high_pct = 85;
				default: sda_high_pct = 15;
			endcase
			repeat (TICKS_PER_RANDOM_PHASE)
				push_tick(3'($urandom_range(7)), 8'($urandom_range(255)), pick_sda());
			settle();
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_bus_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
